FILE: sv/fmq_pkg.sv
`timescale 1ns / 1ps
package fmq_pkg;
  localparam int unsigned MsgW = 16 + 32 + 64 + 64;
  localparam logic [31:0] CODE_NO_LIMIT = 32'hFFFF_FFFF;
  localparam logic [31:0] QUIT_CODE_RESET = 32'd18;
  localparam logic [1:0] QUIT_CODE_ADDR = 2'd0;

  typedef enum logic [1:0] {
    OP_POST = 2'd0,
    OP_GET = 2'd1,
    OP_PEEK_KEEP = 2'd2,
    OP_PEEK_REMOVE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_POSTED = 3'd0,
    ST_DROP_QUIT = 3'd1,
    ST_DROP_FULL = 3'd2,
    ST_FOUND = 3'd3,
    ST_QUIT = 3'd4,
    ST_NONE = 3'd5
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_SCHK = 6'b000100,
    S_SHRD = 6'b001000,
    S_SHWR = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  typedef struct packed {
    logic [15:0] window;
    logic [31:0] code;
    logic [63:0] word_param;
    logic [63:0] long_param;
  } msg_t;
endpackage

FILE: sv/filtered_message_queue.sv
`timescale 1ns / 1ps
// filtered message queue: ordered store of messages with filtered removal
// input: pulse start while busy is low with opcode_i and its fields;
// busy stays high until the result strobe valid_o has been shown
// result: status_o and the message fields are valid for exactly one cycle
// while valid_o is high; the receiver cannot stall, so no back-pressure
// sequence after the accepting edge: a post writes its entry in the scan
// state and then strobes from done; a get or peek reads one entry at a time
// from the single read port of the message ram, each entry passing a scan
// and a check state; a hit that is removed then moves each later entry up
// through a read and a write state, and a last read state leads to the strobe
// one word at a time: the next start is taken once busy has fallen
// quit_code is an apb register at address 0, reset 18; write it only idle
// reset empties the store and clears the quit flag at once; the ram
// contents are left as they are, entries past the count are never read
module filtered_message_queue
  import fmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] window_i,
  input  logic [31:0] msg_code_i,
  input  logic [63:0] word_param_i,
  input  logic [63:0] long_param_i,
  input  logic [31:0] filter_min_i,
  input  logic [31:0] filter_max_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] out_window_o,
  output logic [31:0] out_code_o,
  output logic [63:0] out_word_param_o,
  output logic [63:0] out_long_param_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FullCnt = CW'(QUEUE_DEPTH);

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic quit_q, quit_d;
  logic [31:0] quit_code_q;
  logic [CW-1:0] idx_q, idx_d;
  logic [1:0] op_q;
  logic [15:0] win_q;
  logic [31:0] lo_q, hi_q;
  msg_t post_q;
  msg_t res_q, res_d;
  logic [2:0] st_q, st_d;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  msg_t ram_wdata, ram_rdata;

  fmq_ram #(.Width(MsgW), .Depth(QUEUE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr == QUIT_CODE_ADDR) ? quit_code_q : 32'd0;
  assign busy = (state_q != S_IDLE);
  assign valid_o = (state_q == S_DONE);
  assign status_o = st_q;
  assign out_window_o = res_q.window;
  assign out_code_o = res_q.code;
  assign out_word_param_o = res_q.word_param;
  assign out_long_param_o = res_q.long_param;

  logic hit;
  logic is_quit;
  always_comb begin
    hit = ((win_q == 16'd0) || (ram_rdata.window == win_q)) &&
          (ram_rdata.code >= lo_q) && (ram_rdata.code <= hi_q);
    is_quit = (op_q == OP_GET) && (ram_rdata.code == quit_code_q);
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    quit_d = quit_q;
    idx_d = idx_q;
    res_d = res_q;
    st_d = st_q;
    ram_we = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          idx_d = '0;
          res_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (op_q == OP_POST) begin
          state_d = S_DONE;
          if (quit_q) st_d = ST_DROP_QUIT;
          else if (count_q >= FullCnt) st_d = ST_DROP_FULL;
          else begin
            ram_we = 1'b1;
            ram_waddr = count_q[AW-1:0];
            ram_wdata = post_q;
            count_d = count_q + 1'b1;
            st_d = ST_POSTED;
          end
        end else if (idx_q >= count_q) begin
          st_d = ST_NONE;
          state_d = S_DONE;
        end else begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (is_quit) begin
          quit_d = 1'b1;
          count_d = '0;
          st_d = ST_QUIT;
          state_d = S_DONE;
        end else if (hit) begin
          st_d = ST_FOUND;
          res_d = ram_rdata;
          if (op_q == OP_PEEK_KEEP) state_d = S_DONE;
          else state_d = S_SHRD;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SHRD: begin
        // read the successor of the gap, if any
        if (idx_q + 1'b1 >= count_q) begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end else begin
          ram_raddr = AW'(idx_q + 1'b1);
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        ram_we = 1'b1;
        ram_wdata = ram_rdata;
        idx_d = idx_q + 1'b1;
        state_d = S_SHRD;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      quit_q <= 1'b0;
      quit_code_q <= QUIT_CODE_RESET;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      quit_q <= quit_d;
      if (psel && penable && pwrite && pready && paddr == QUIT_CODE_ADDR)
        quit_code_q <= pwdata;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    res_q <= res_d;
    st_q <= st_d;
    if (state_q == S_IDLE && start) begin
      op_q <= opcode_i;
      win_q <= window_i;
      lo_q <= filter_min_i;
      hi_q <= (filter_max_i == 32'd0) ? CODE_NO_LIMIT : filter_max_i;
      post_q <= '{window: window_i, code: msg_code_i,
                  word_param: word_param_i, long_param: long_param_i};
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("count beyond depth");
  a_quit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && st_q == ST_QUIT) |-> (count_q == '0)) else $error("quit left entries");
  a_post_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && st_q == ST_POSTED) |-> (count_q == $past(count_q) + 1'b1 ||
    count_q == $past(count_q))) else $error("post count");
  a_quit_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(quit_q) |-> quit_q) else $error("quit flag cleared");
`endif
endmodule

FILE: sv/fmq_ram.sv
`timescale 1ns / 1ps
module fmq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: verif/fmq_checker.sv
`timescale 1ns / 1ps
module fmq_checker
  import fmq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] window_i,
  input  logic [31:0] msg_code_i,
  input  logic [63:0] word_param_i,
  input  logic [63:0] long_param_i,
  input  logic [31:0] filter_min_i,
  input  logic [31:0] filter_max_i,
  input  logic        valid_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] out_window_i,
  input  logic [31:0] out_code_i,
  input  logic [63:0] out_word_param_i,
  input  logic [63:0] out_long_param_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [2:0] status;
    msg_t       msg;
  } reply_t;

  msg_t        held_msgs[QUEUE_DEPTH];
  int unsigned held_count;
  bit          quit_flag;
  logic [31:0] quit_val;
  reply_t      awaited_replies[$];

  // one request against the store, state updated in place
  function automatic reply_t serve_request(op_e op, msg_t req, logic [31:0] lo,
                                           logic [31:0] hi_in);
    reply_t      r;
    logic [31:0] hi;
    int unsigned k;
    int unsigned j;
    r.status = ST_NONE;
    r.msg = '0;
    hi = (hi_in == 32'd0) ? CODE_NO_LIMIT : hi_in;
    if (op == OP_POST) begin
      if (quit_flag) begin
        r.status = ST_DROP_QUIT;
      end else if (held_count >= QUEUE_DEPTH) begin
        r.status = ST_DROP_FULL;
      end else begin
        held_msgs[held_count] = req;
        held_count++;
        r.status = ST_POSTED;
      end
      return r;
    end
    for (k = 0; k < held_count; k++) begin
      if (op == OP_GET && held_msgs[k].code == quit_val) begin
        quit_flag = 1'b1;
        held_count = 0;
        r.status = ST_QUIT;
        return r;
      end
      if ((req.window == 16'd0 || held_msgs[k].window == req.window) &&
          held_msgs[k].code >= lo && held_msgs[k].code <= hi) begin
        r.status = ST_FOUND;
        r.msg = held_msgs[k];
        if (op != OP_PEEK_KEEP) begin
          for (j = k; j + 1 < held_count; j++) held_msgs[j] = held_msgs[j + 1];
          held_count--;
        end
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    msg_t   req;
    if (!rst_ni) begin
      held_count = 0;
      quit_flag = 1'b0;
      quit_val = QUIT_CODE_RESET;
      fail_count_o = 0;
      awaited_replies.delete();
    end else begin
      if (valid_i) begin
        got.status = status_i;
        got.msg = {out_window_i, out_code_i, out_word_param_i, out_long_param_i};
        if (awaited_replies.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result word: status %0d code %h", status_i, out_code_i);
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"mismatch: exp st %0d win %h code %h w %h l %h",
                        " / got st %0d win %h code %h w %h l %h"},
                       want.status, want.msg.window, want.msg.code, want.msg.word_param,
                       want.msg.long_param, got.status, got.msg.window, got.msg.code,
                       got.msg.word_param, got.msg.long_param);
          end
        end
      end
      if (start_i && !busy_i) begin
        req = {window_i, msg_code_i, word_param_i, long_param_i};
        awaited_replies.push_back(serve_request(op_e'(opcode_i), req, filter_min_i,
                                                filter_max_i));
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == QUIT_CODE_ADDR)
        quit_val = pwdata_i;
    end
    pending_o = awaited_replies.size();
  end

endmodule

FILE: verif/tb_filtered_message_queue.sv
`timescale 1ns / 1ps
module tb_filtered_message_queue;
  import fmq_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = OP_POST;
  logic [15:0] window_i = '0;
  logic [31:0] msg_code_i = '0;
  logic [63:0] word_param_i = '0;
  logic [63:0] long_param_i = '0;
  logic [31:0] filter_min_i = '0;
  logic [31:0] filter_max_i = '0;
  logic        valid_o;
  logic [2:0]  status_o;
  logic [15:0] out_window_o;
  logic [31:0] out_code_o;
  logic [63:0] out_word_param_o;
  logic [63:0] out_long_param_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;

  logic [31:0] quit_now = QUIT_CODE_RESET;
  bit          calm;
  int unsigned post_weight;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  filtered_message_queue u_top (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .window_i, .msg_code_i,
    .word_param_i, .long_param_i, .filter_min_i, .filter_max_i, .valid_o,
    .status_o, .out_window_o, .out_code_o, .out_word_param_o, .out_long_param_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  fmq_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .opcode_i, .window_i,
    .msg_code_i, .word_param_i, .long_param_i, .filter_min_i, .filter_max_i,
    .valid_i(valid_o), .status_i(status_o), .out_window_i(out_window_o),
    .out_code_i(out_code_o), .out_word_param_i(out_word_param_o),
    .out_long_param_i(out_long_param_o), .psel_i(psel), .penable_i(penable),
    .pwrite_i(pwrite), .pready_i(pready), .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // called right after a rising edge; start held high across back-to-back words
  task automatic send_word(op_e op, logic [15:0] win, logic [31:0] code,
                           logic [63:0] wp, logic [63:0] lp, logic [31:0] lo,
                           logic [31:0] hi);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    window_i <= win;
    msg_code_i <= code;
    word_param_i <= wp;
    long_param_i <= lp;
    filter_min_i <= lo;
    filter_max_i <= hi;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_quit_code(logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= QUIT_CODE_ADDR;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    quit_now = val;
    @(posedge clk_i);
  endtask

  // keeps the quit code out of the store until the closing phase
  function automatic logic [31:0] pick_code(bit allow_quit);
    logic [31:0] c;
    case ($urandom_range(0, 9))
      6: c = 32'hFFFF_FFFF;
      7: c = 32'd0;
      8, 9: c = $urandom;
      default: c = $urandom_range(0, 15);
    endcase
    if (!allow_quit && c == quit_now) c = c ^ 32'd1;
    return c;
  endfunction

  function automatic logic [15:0] pick_window(bit is_filter);
    case ($urandom_range(0, 9))
      0: return is_filter ? 16'd0 : 16'hFFFF;
      1: return 16'($urandom);
      2, 3: return is_filter ? 16'd0 : 16'd1;
      default: return 16'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic logic [31:0] pick_lo;
    case ($urandom_range(0, 7))
      0, 1, 2: return 32'd0;
      3: return $urandom;
      4: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic logic [31:0] pick_hi;
    case ($urandom_range(0, 7))
      0, 1, 2: return 32'd0;
      3: return $urandom;
      4: return 32'hFFFF_FFFF;
      default: return $urandom_range(3, 20);
    endcase
  endfunction

  task automatic random_word(bit allow_quit);
    op_e op;
    if ($urandom_range(0, 99) < post_weight) op = OP_POST;
    else op = op_e'($urandom_range(1, 3));
    if (op == OP_POST)
      send_word(op, pick_window(1'b0), pick_code(allow_quit), {$urandom, $urandom},
                {$urandom, $urandom}, pick_lo(), pick_hi());
    else
      send_word(op, pick_window(1'b1), pick_code(allow_quit), {$urandom, $urandom},
                {$urandom, $urandom}, pick_lo(), pick_hi());
  endtask

  initial begin
    logic [31:0] quit_choices[4];
    quit_choices = '{32'hFFFF_FFFF, 32'd0, 32'h7FFF_0000, 32'h0};
    quit_choices[3] = $urandom | 32'h100;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words, quit code still 18
    calm = 1'b0;
    send_word(OP_POST, 16'd1, 32'd5, '0, '0, '0, '0);
    send_word(OP_POST, 16'hFFFF, 32'hFFFF_FFFF, '1, '1, '1, '1);
    send_word(OP_POST, 16'd0, 32'd0, 64'h5555_AAAA_0F0F_F0F0, 64'h1234, '0, '0);
    send_word(OP_POST, 16'd2, 32'd18, 64'd7, 64'd8, '0, '0);
    send_word(OP_PEEK_KEEP, 16'd0, '0, '0, '0, 32'd0, 32'd0);
    send_word(OP_PEEK_KEEP, 16'd2, '0, '0, '0, 32'd18, 32'd18);
    send_word(OP_PEEK_REMOVE, 16'd2, '0, '0, '0, 32'd18, 32'd18);
    send_word(OP_GET, 16'hFFFF, '0, '0, '0, 32'd0, 32'd0);
    send_word(OP_GET, 16'd0, '0, '0, '0, 32'd10, 32'd3);
    send_word(OP_GET, 16'd7, '0, '0, '0, 32'd0, 32'd0);
    send_word(OP_PEEK_REMOVE, 16'd0, '0, '0, '0, 32'd0, 32'd4);
    send_word(OP_GET, 16'd0, '0, '0, '0, 32'hFFFF_FFFF, 32'd0);
    send_word(OP_GET, 16'd1, '0, '0, '0, 32'd0, 32'd0);
    send_word(OP_GET, 16'd0, '0, '0, '0, 32'd0, 32'd0);
    send_word(OP_PEEK_KEEP, 16'd0, '0, '0, '0, 32'd0, 32'd0);
    drain();

    foreach (quit_choices[p]) begin
      write_quit_code(quit_choices[p]);
      for (int n = 0; n < 340; n++) begin
        if (n % 85 == 0) begin
          post_weight = (n % 170 == 0) ? 85 : 40;
          calm = ($urandom_range(0, 3) == 0);
        end
        random_word(1'b0);
        // sender holds off once until everything is back
        if (p == 1 && n == 170) drain();
      end
      drain();
    end

    // closing phase: quit is taken, then every post is dropped
    write_quit_code(QUIT_CODE_RESET);
    calm = 1'b0;
    post_weight = 60;
    for (int n = 0; n < 30; n++) random_word(1'b0);
    send_word(OP_POST, 16'd3, QUIT_CODE_RESET, '1, '0, '0, '0);
    send_word(OP_GET, 16'd0, '0, '0, '0, QUIT_CODE_RESET, QUIT_CODE_RESET);
    for (int n = 0; n < 40; n++) random_word(1'b1);
    drain();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
